// File: hdl/rfde_pkg.sv
package rfde_pkg;

  // command codes
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_WR_COL = 3'd1;
  localparam logic [2:0] CMD_WR_RGB = 3'd2;
  localparam logic [2:0] CMD_BRUSH  = 3'd3;
  localparam logic [2:0] CMD_HLINE  = 3'd4;
  localparam logic [2:0] CMD_VLINE  = 3'd5;
  localparam logic [2:0] CMD_RECT   = 3'd6;
  localparam logic [2:0] CMD_READ   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EDGE    = 2'd2;

  // config register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_READ,
    OP_FILL
  } op_e;

  typedef struct packed {
    logic [8:0] r0;
    logic [8:0] r1;
    logic [8:0] c0;
    logic [8:0] c1;
    logic       empty;
  } box_t;

  typedef struct packed {
    op_e         kind;
    logic [1:0]  status;
    logic [15:0] color;
    box_t        box;
    logic        last;
  } entry_t;

  // low edge grown down by grow, clipped at zero
  function automatic logic [8:0] clip_lo(input logic [8:0] a, input logic [7:0] grow);
    logic [8:0] g;
    g = {1'b0, grow};
    return (a >= g) ? (a - g) : 9'd0;
  endfunction

  // high edge grown up by grow, clipped at lim
  function automatic logic [8:0] clip_hi(input logic [8:0] b, input logic [7:0] grow,
                                         input logic [8:0] lim);
    logic [9:0] s;
    s = {1'b0, b} + {2'b0, grow};
    return (s > {1'b0, lim}) ? lim : s[8:0];
  endfunction

  // brush-grown box clipped to the frame
  function automatic box_t make_box(input logic [8:0] r0, input logic [8:0] r1,
                                    input logic [8:0] c0, input logic [8:0] c1,
                                    input logic [7:0] size,
                                    input logic [8:0] w, input logic [8:0] h);
    box_t b;
    logic [7:0] grow;
    grow = size - 8'd1;
    b.r0 = clip_lo(r0, grow);
    b.c0 = clip_lo(c0, grow);
    b.r1 = clip_hi(r1, grow, h - 9'd1);
    b.c1 = clip_hi(c1, grow, w - 9'd1);
    b.empty = (size == 8'd0) || (b.r0 > b.r1) || (b.c0 > b.c1);
    return b;
  endfunction

endpackage

// File: hdl/rgb565_frame_draw_engine_core.sv
// after reset the frame store is zeroed by a sweep of every address, no words taken
// pixel write: front, queue, then S_IDLE, S_BASE, S_WR and S_RES; read: S_RD and S_RDW in place of S_WR
// brush and line: S_BASE, then one S_FILL write per covered pixel; rectangle: S_IDLE and S_BASE again
// per further edge, on the single frame store write port; clear: S_CLR zeroes every address
// one command in flight in the front, up to 4 queued edges, one result held at the output
// reset sets frame width and height to 64
module rgb565_frame_draw_engine_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] color_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  brush_size_i,
  input  logic [8:0]  x0_i,
  input  logic [8:0]  y0_i,
  input  logic [8:0]  x1_i,
  input  logic [8:0]  y1_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] pixel_o
);
  import rfde_pkg::*;

  logic [8:0] width_q, height_q, width, height;
  logic       init_busy, q_full, q_push, q_valid, q_pop;
  entry_t     push_ent, pop_ent;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd64;
      height_q <= 9'd64;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) width_q <= cfg_wdata_i;
      else height_q <= cfg_wdata_i;
    end
  end

  // clamp to the usable range
  always_comb begin
    if (width_q == 9'd0) width = 9'd1;
    else if (int'(width_q) > MAX_WIDTH) width = 9'(MAX_WIDTH);
    else width = width_q;
    if (height_q == 9'd0) height = 9'd1;
    else if (int'(height_q) > MAX_HEIGHT) height = 9'(MAX_HEIGHT);
    else height = height_q;
  end

  rfde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .color_i      (color_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .brush_size_i (brush_size_i),
    .x0_i         (x0_i),
    .y0_i         (y0_i),
    .x1_i         (x1_i),
    .y1_i         (y1_i),
    .init_busy_i  (init_busy),
    .width_i      (width),
    .height_i     (height),
    .full_i       (q_full),
    .push_o       (q_push),
    .ent_o        (push_ent)
  );

  rfde_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_ent),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_ent),
    .valid_o     (q_valid)
  );

  rfde_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_i       (pop_ent),
    .ent_pop_o   (q_pop),
    .width_i     (width),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .pixel_o     (pixel_o)
  );

endmodule

// File: hdl/rfde_queue.sv
module rfde_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfde_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output rfde_pkg::entry_t pop_data_o,
  output logic             valid_o
);
  import rfde_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  entry_t          mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == (PW+1)'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: hdl/rfde_front.sv
module rfde_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [15:0]      color_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       brush_size_i,
  input  logic [8:0]       x0_i,
  input  logic [8:0]       y0_i,
  input  logic [8:0]       x1_i,
  input  logic [8:0]       y1_i,
  input  logic             init_busy_i,
  input  logic [8:0]       width_i,
  input  logic [8:0]       height_i,
  input  logic             full_i,
  output logic             push_o,
  output rfde_pkg::entry_t ent_o
);
  import rfde_pkg::*;

  logic        busy_q;
  logic [1:0]  edge_q;
  logic [2:0]  cmd_q;
  logic [15:0] color_q;
  logic [7:0]  red_q, green_q, blue_q, size_q;
  logic [8:0]  x0_q, y0_q, x1_q, y1_q;
  logic        p0_in, x_in, y_in;

  assign in_ready_o = !busy_q && !init_busy_i;
  assign push_o     = busy_q;

  // item capture and edge sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      edge_q <= '0;
    end else if (!busy_q) begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
        edge_q <= '0;
      end
    end else if (!full_i) begin
      if (ent_o.last) busy_q <= 1'b0;
      else edge_q <= edge_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      color_q <= color_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      size_q  <= brush_size_i;
      x0_q    <= x0_i;
      y0_q    <= y0_i;
      x1_q    <= x1_i;
      y1_q    <= y1_i;
    end
  end

  assign p0_in = (x0_q < width_i) && (y0_q < height_i);
  assign x_in  = (x0_q < width_i) && (x1_q < width_i);
  assign y_in  = (y0_q < height_i) && (y1_q < height_i);

  // classify the held word into queue entries
  always_comb begin
    ent_o        = '0;
    ent_o.kind   = OP_NONE;
    ent_o.status = ST_OK;
    ent_o.color  = color_q;
    ent_o.last   = 1'b1;
    case (cmd_q)
      CMD_CLEAR: ent_o.kind = OP_CLEAR;
      CMD_WR_COL, CMD_WR_RGB: begin
        if (!p0_in) begin
          ent_o.status = ST_INVALID;
        end else begin
          ent_o.kind   = OP_WRITE;
          ent_o.box.r0 = y0_q;
          ent_o.box.c0 = x0_q;
          if (cmd_q == CMD_WR_RGB)
            ent_o.color = {red_q[4:0], green_q[5:0], blue_q[4:0]};
        end
      end
      CMD_BRUSH: begin
        if (size_q == 8'd0) begin
          ent_o.status = ST_INVALID;
        end else begin
          ent_o.kind = OP_FILL;
          ent_o.box  = make_box(y0_q, y0_q, x0_q, x0_q, size_q, width_i, height_i);
        end
      end
      CMD_HLINE: begin
        if (x0_q > x1_q || !x_in || y0_q >= height_i) begin
          ent_o.status = ST_INVALID;
        end else begin
          ent_o.kind = OP_FILL;
          ent_o.box  = make_box(y0_q, y0_q, x0_q, x1_q, size_q, width_i, height_i);
        end
      end
      CMD_VLINE: begin
        if (y0_q > y1_q || !y_in || x0_q >= width_i) begin
          ent_o.status = ST_INVALID;
        end else begin
          ent_o.kind = OP_FILL;
          ent_o.box  = make_box(y0_q, y1_q, x0_q, x0_q, size_q, width_i, height_i);
        end
      end
      CMD_RECT: begin
        if (!x_in || !y_in) begin
          ent_o.status = ST_INVALID;
        end else if (x0_q > x1_q) begin
          ent_o.status = ST_EDGE;
        end else begin
          ent_o.kind = OP_FILL;
          case (edge_q)
            2'd0: begin
              ent_o.last = 1'b0;
              ent_o.box  = make_box(y0_q, y0_q, x0_q, x1_q, size_q, width_i, height_i);
            end
            2'd1: begin
              ent_o.last = (y0_q > y1_q);
              if (y0_q > y1_q) ent_o.status = ST_EDGE;
              ent_o.box  = make_box(y1_q, y1_q, x0_q, x1_q, size_q, width_i, height_i);
            end
            2'd2: begin
              ent_o.last = 1'b0;
              ent_o.box  = make_box(y0_q, y1_q, x0_q, x0_q, size_q, width_i, height_i);
            end
            default: begin
              ent_o.box  = make_box(y0_q, y1_q, x1_q, x1_q, size_q, width_i, height_i);
            end
          endcase
        end
      end
      default: begin
        if (!p0_in) begin
          ent_o.status = ST_INVALID;
        end else begin
          ent_o.kind   = OP_READ;
          ent_o.box.r0 = y0_q;
          ent_o.box.c0 = x0_q;
        end
      end
    endcase
  end

endmodule

// File: hdl/rfde_back.sv
module rfde_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ent_valid_i,
  input  rfde_pkg::entry_t ent_i,
  output logic             ent_pop_o,
  input  logic [8:0]       width_i,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      pixel_o
);
  import rfde_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_BASE = 4'd2;
  localparam logic [3:0] S_FILL = 4'd3;
  localparam logic [3:0] S_WR   = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_RDW  = 4'd6;
  localparam logic [3:0] S_CLR  = 4'd7;
  localparam logic [3:0] S_RES  = 4'd8;

  logic [15:0]   mem [Depth];
  logic [3:0]    state_q;
  entry_t        cur_q;
  logic [AW-1:0] base_q, clr_q, pix_addr, waddr;
  logic [8:0]    r_q, c_q;
  logic [1:0]    pend_status_q, status_q;
  logic [15:0]   pend_pixel_q, pixel_q, rd_q, wdata;
  logic          out_valid_q, we;
  logic [17:0]   prod;

  assign init_busy_o = (state_q == S_INIT);
  assign ent_pop_o   = (state_q == S_IDLE) && ent_valid_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pixel_o     = pixel_q;
  assign pix_addr    = base_q + AW'(c_q);
  assign prod        = 18'(cur_q.box.r0) * 18'(width_i);

  // frame store port select
  always_comb begin
    we    = 1'b0;
    waddr = pix_addr;
    wdata = cur_q.color;
    case (state_q)
      S_INIT, S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      S_FILL, S_WR: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[pix_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && (state_q != S_RES)) out_valid_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          if (clr_q == AW'(Depth - 1)) state_q <= S_IDLE;
          else clr_q <= clr_q + 1'b1;
        end
        S_IDLE: begin
          if (ent_valid_i) begin
            cur_q         <= ent_i;
            pend_status_q <= ent_i.status;
            pend_pixel_q  <= '0;
            clr_q         <= '0;
            case (ent_i.kind)
              OP_CLEAR: state_q <= S_CLR;
              OP_WRITE, OP_READ: state_q <= S_BASE;
              OP_FILL: begin
                if (ent_i.box.empty) state_q <= ent_i.last ? S_RES : S_IDLE;
                else state_q <= S_BASE;
              end
              default: state_q <= ent_i.last ? S_RES : S_IDLE;
            endcase
          end
        end
        S_BASE: begin
          base_q <= AW'(prod);
          r_q    <= cur_q.box.r0;
          c_q    <= cur_q.box.c0;
          case (cur_q.kind)
            OP_WRITE: state_q <= S_WR;
            OP_READ:  state_q <= S_RD;
            default:  state_q <= S_FILL;
          endcase
        end
        S_FILL: begin
          if (c_q == cur_q.box.c1) begin
            if (r_q == cur_q.box.r1) begin
              state_q <= cur_q.last ? S_RES : S_IDLE;
            end else begin
              r_q    <= r_q + 9'd1;
              c_q    <= cur_q.box.c0;
              base_q <= base_q + AW'(width_i);
            end
          end else begin
            c_q <= c_q + 9'd1;
          end
        end
        S_WR: state_q <= cur_q.last ? S_RES : S_IDLE;
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          pend_pixel_q <= rd_q;
          state_q      <= S_RES;
        end
        S_CLR: begin
          if (clr_q == AW'(Depth - 1)) state_q <= cur_q.last ? S_RES : S_IDLE;
          else clr_q <= clr_q + 1'b1;
        end
        S_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= pend_status_q;
            pixel_q     <= pend_pixel_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
